// ===== sv/icd_pkg.sv =====
package icd_pkg;

    // field and register widths
    localparam int MV_W      = 16;
    localparam int PCT_W     = 7;
    localparam int IR_W      = 8;
    localparam int LIM_W     = 15;
    localparam int SHIFT_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = 24;
    localparam int CNT_W     = 5;

    // constants
    localparam logic [PCT_W-1:0]  PCT_FULL = 7'd100;
    localparam logic [MV_W-1:0]   MV_MAX   = 16'hFFFF;
    localparam logic [MV_W-1:0]   DIV_TEN  = 16'd10;

    // divider step counts: full width for the divide by ten, seven for the cap
    // quotient, which is always below 128
    localparam logic [CNT_W-1:0]  IR_DIV_ITERS  = 5'd24;
    localparam logic [CNT_W-1:0]  CAP_DIV_ITERS = 5'd7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KNEE_MV      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_MV     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_PCT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IR_MILLIOHM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COMP_MAX_MV  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_SHIFT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_FLOOR_MV = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_MV   = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_IR,
        ST_DIV_IR,
        ST_SUM,
        ST_FILT,
        ST_CAP,
        ST_MUL_CAP,
        ST_DIV_CAP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              start;
        logic [MV_W-1:0]   a;
        logic [IR_W-1:0]   b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic              start;
        logic [MV_W-1:0]   rem0;
        logic [PROD_W-1:0] num;
        logic [MV_W-1:0]   divisor;
        logic [CNT_W-1:0]  iters;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quo;
    } div_rsp_t;

endpackage

// ===== sv/icd_ser_mult.sv =====
module icd_ser_mult (
    input  logic              aclk,
    input  logic              aresetn,
    input  icd_pkg::mul_req_t req,
    output icd_pkg::mul_rsp_t rsp
);
    import icd_pkg::*;

    localparam int STEP_W = $clog2(IR_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [PROD_W-1:0] a_reg, a_next;
    logic [IR_W-1:0]   b_reg, b_next;
    logic [PROD_W-1:0] acc_reg, acc_next;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    // one multiplier bit per cycle, LSB first: add, shift multiplicand up
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = PROD_W'(req.a);
            b_next    = req.b;
            acc_next  = '0;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = a_reg << 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(IR_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

// ===== sv/icd_ser_div.sv =====
module icd_ser_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  icd_pkg::div_req_t req,
    output icd_pkg::div_rsp_t rsp
);
    import icd_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [MV_W-1:0]   rem_reg, rem_next;
    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [MV_W-1:0]   dvs_reg, dvs_next;
    logic [MV_W:0]     trial;
    logic              fits;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    // restoring division: shift one dividend bit into the remainder per cycle,
    // shift the quotient bit in at the bottom of the same register
    always_comb begin
        trial     = {rem_reg, quo_reg[PROD_W-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = req.iters;
            rem_next  = req.rem0;
            quo_next  = req.num;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = MV_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_next = trial[MV_W-1:0];
            end
            quo_next = {quo_reg[PROD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== sv/ir_compensated_cell_derate.sv =====
// Channel   Direction  Handshake           Word
// s_        in         s_valid / s_ready   voltage, current and freshness flags
// m_        out        m_valid / m_ready   raw, correction, estimate, cap, flags
// cfg_      in         cfg_wr_en           register index and write data
//
// One word at a time. An unusable voltage goes from acceptance straight to the
// final state; other words pass the sum, filter and cap states, and correction and
// interpolation each add a multiply and a divide. s_ready rises on the same edge
// as m_valid. The multiplier is bit-serial (8 steps, used twice) and the restoring
// divider takes 24 steps for the divide by ten and 7 for the cap quotient.
// Reset is synchronous, active low; it clears control state and the filter.
// A result waiting on m_ready holds only the final state; the next word is
// accepted as soon as the previous one has moved to the output register.
module ir_compensated_cell_derate #(
    parameter int FRAC_BITS = 8
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic                                   s_volt_fresh,
    input  logic [icd_pkg::MV_W-1:0]               s_cell_min_mv,
    input  logic                                   s_amp_fresh,
    input  logic signed [icd_pkg::MV_W-1:0]        s_pack_curr,

    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [icd_pkg::MV_W-1:0]               m_raw_mv,
    output logic signed [icd_pkg::MV_W-1:0]        m_corr_mv,
    output logic [icd_pkg::MV_W-1:0]               m_ocv_est_mv,
    output logic [icd_pkg::PCT_W-1:0]              m_cap_pct,
    output logic                                   m_is_capped,
    output logic                                   m_was_compensated,
    output logic                                   m_hit_raw_floor,

    input  logic                                   cfg_wr_en,
    input  logic [icd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [icd_pkg::MV_W-1:0]               cfg_wdata
);
    import icd_pkg::*;

    localparam int ACC_W = MV_W + FRAC_BITS;

    // configuration
    logic [MV_W-1:0]    knee_reg, floor_reg, raw_floor_reg, default_reg;
    logic [PCT_W-1:0]   floor_pct_reg;
    logic [IR_W-1:0]    ir_reg;
    logic [LIM_W-1:0]   comp_max_reg;
    logic [SHIFT_W-1:0] shift_reg;

    // control and filter state
    state_t             state_reg, state_next;
    logic               seeded_reg, seeded_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic               m_valid_reg, m_valid_next;

    // per-word working registers
    logic [MV_W-1:0]    vmin_reg, vmin_next;
    logic               neg_reg, neg_next;
    logic [MV_W-1:0]    corr_reg, corr_next;
    logic               comped_reg, comped_next;
    logic [MV_W-1:0]    est_reg, est_next;
    logic [MV_W-1:0]    ocv_reg, ocv_next;
    logic [PCT_W-1:0]   cap_reg, cap_next;
    logic               hit_reg, hit_next;

    // output register
    logic [MV_W-1:0]    m_raw_reg, m_raw_next;
    logic [MV_W-1:0]    m_corr_reg, m_corr_next;
    logic [MV_W-1:0]    m_ocv_reg, m_ocv_next;
    logic [PCT_W-1:0]   m_cap_reg, m_cap_next;
    logic               m_capped_reg, m_capped_next;
    logic               m_comped_reg, m_comped_next;
    logic               m_hit_reg, m_hit_next;

    // combinational helpers
    mul_req_t           mul_req;
    mul_rsp_t           mul_rsp;
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    logic [MV_W-1:0]    cur_bits, cur_mag;
    logic [PCT_W-1:0]   fp_eff;
    logic [LIM_W-1:0]   corr_mag;
    logic [MV_W-1:0]    corr_mag16;
    logic [MV_W+1:0]    sum;
    logic [ACC_W-1:0]   target;
    logic signed [ACC_W:0] diff, step;

    icd_ser_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    icd_ser_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            knee_reg      <= 16'd3500;
            floor_reg     <= 16'd3000;
            floor_pct_reg <= 7'd20;
            ir_reg        <= 8'd0;
            comp_max_reg  <= 15'd500;
            shift_reg     <= 4'd3;
            raw_floor_reg <= 16'd2800;
            default_reg   <= 16'd3600;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_KNEE_MV:      knee_reg      <= cfg_wdata;
                REG_FLOOR_MV:     floor_reg     <= cfg_wdata;
                REG_FLOOR_PCT:    floor_pct_reg <= cfg_wdata[PCT_W-1:0];
                REG_IR_MILLIOHM:  ir_reg        <= cfg_wdata[IR_W-1:0];
                REG_COMP_MAX_MV:  comp_max_reg  <= cfg_wdata[LIM_W-1:0];
                REG_FILTER_SHIFT: shift_reg     <= cfg_wdata[SHIFT_W-1:0];
                REG_RAW_FLOOR_MV: raw_floor_reg <= cfg_wdata;
                REG_DEFAULT_MV:   default_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            seeded_reg  <= 1'b0;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            seeded_reg  <= seeded_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        vmin_reg     <= vmin_next;
        neg_reg      <= neg_next;
        corr_reg     <= corr_next;
        comped_reg   <= comped_next;
        est_reg      <= est_next;
        ocv_reg      <= ocv_next;
        cap_reg      <= cap_next;
        hit_reg      <= hit_next;
        m_raw_reg    <= m_raw_next;
        m_corr_reg   <= m_corr_next;
        m_ocv_reg    <= m_ocv_next;
        m_cap_reg    <= m_cap_next;
        m_capped_reg <= m_capped_next;
        m_comped_reg <= m_comped_next;
        m_hit_reg    <= m_hit_next;
    end

    // shared datapath terms
    always_comb begin
        cur_bits   = s_pack_curr;
        cur_mag    = cur_bits[MV_W-1] ? (~cur_bits + 1'b1) : cur_bits;
        fp_eff     = (floor_pct_reg > PCT_FULL) ? PCT_FULL : floor_pct_reg;
        corr_mag   = (div_rsp.quo > PROD_W'(comp_max_reg)) ? comp_max_reg
                                                            : div_rsp.quo[LIM_W-1:0];
        corr_mag16 = {1'b0, corr_mag};
        sum        = {2'b00, vmin_reg} + {{2{corr_reg[MV_W-1]}}, corr_reg};
        target     = {est_reg, {FRAC_BITS{1'b0}}};
        diff       = $signed({1'b0, target}) - $signed({1'b0, acc_reg});
        step       = diff >>> shift_reg;
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        seeded_next   = seeded_reg;
        acc_next      = acc_reg;
        vmin_next     = vmin_reg;
        neg_next      = neg_reg;
        corr_next     = corr_reg;
        comped_next   = comped_reg;
        est_next      = est_reg;
        ocv_next      = ocv_reg;
        cap_next      = cap_reg;
        hit_next      = hit_reg;
        m_raw_next    = m_raw_reg;
        m_corr_next   = m_corr_reg;
        m_ocv_next    = m_ocv_reg;
        m_cap_next    = m_cap_reg;
        m_capped_next = m_capped_reg;
        m_comped_next = m_comped_reg;
        m_hit_next    = m_hit_reg;
        mul_req       = '0;
        div_req       = '0;

        // drop the output word once taken
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    vmin_next = s_cell_min_mv;
                    neg_next  = cur_bits[MV_W-1];
                    if (!s_volt_fresh || (s_cell_min_mv == '0)) begin
                        // unusable voltage: unseed and report defaults
                        seeded_next = 1'b0;
                        corr_next   = '0;
                        comped_next = 1'b0;
                        ocv_next    = default_reg;
                        cap_next    = PCT_FULL;
                        hit_next    = 1'b0;
                        state_next  = ST_DONE;
                    end else if (s_amp_fresh && (ir_reg != '0)) begin
                        comped_next   = 1'b1;
                        mul_req.start = 1'b1;
                        mul_req.a     = cur_mag;
                        mul_req.b     = ir_reg;
                        state_next    = ST_MUL_IR;
                    end else begin
                        corr_next   = '0;
                        comped_next = 1'b0;
                        state_next  = ST_SUM;
                    end
                end
            end
            ST_MUL_IR: begin
                // |current| * resistance, then divide by ten
                if (mul_rsp.done) begin
                    div_req.start   = 1'b1;
                    div_req.rem0    = '0;
                    div_req.num     = mul_rsp.prod;
                    div_req.divisor = DIV_TEN;
                    div_req.iters   = IR_DIV_ITERS;
                    state_next      = ST_DIV_IR;
                end
            end
            ST_DIV_IR: begin
                // clamp the magnitude, then restore the sign
                if (div_rsp.done) begin
                    corr_next  = neg_reg ? (~corr_mag16 + 1'b1) : corr_mag16;
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                // saturate voltage plus correction to the unsigned range
                if (sum[MV_W+1]) begin
                    est_next = '0;
                end else if (sum[MV_W]) begin
                    est_next = MV_MAX;
                end else begin
                    est_next = sum[MV_W-1:0];
                end
                state_next = ST_FILT;
            end
            ST_FILT: begin
                // seed, or move by the floor-shifted difference
                if (!seeded_reg) begin
                    acc_next    = target;
                    seeded_next = 1'b1;
                    ocv_next    = est_reg;
                end else begin
                    acc_next = acc_reg + step[ACC_W-1:0];
                    ocv_next = acc_next[ACC_W-1:FRAC_BITS];
                end
                state_next = ST_CAP;
            end
            ST_CAP: begin
                if (vmin_reg <= raw_floor_reg) begin
                    hit_next   = 1'b1;
                    cap_next   = fp_eff;
                    state_next = ST_DONE;
                end else begin
                    hit_next = 1'b0;
                    if (ocv_reg >= knee_reg) begin
                        cap_next   = PCT_FULL;
                        state_next = ST_DONE;
                    end else if (ocv_reg <= floor_reg) begin
                        cap_next   = fp_eff;
                        state_next = ST_DONE;
                    end else begin
                        mul_req.start = 1'b1;
                        mul_req.a     = ocv_reg - floor_reg;
                        mul_req.b     = {1'b0, PCT_FULL - fp_eff};
                        state_next    = ST_MUL_CAP;
                    end
                end
            end
            ST_MUL_CAP: begin
                // quotient is below 128, so the top bits preload the remainder
                if (mul_rsp.done) begin
                    div_req.start   = 1'b1;
                    div_req.rem0    = MV_W'(mul_rsp.prod >> CAP_DIV_ITERS);
                    div_req.num     = mul_rsp.prod << (PROD_W - int'(CAP_DIV_ITERS));
                    div_req.divisor = knee_reg - floor_reg;
                    div_req.iters   = CAP_DIV_ITERS;
                    state_next      = ST_DIV_CAP;
                end
            end
            ST_DIV_CAP: begin
                if (div_rsp.done) begin
                    cap_next   = fp_eff + div_rsp.quo[PCT_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hand the word to the output register when it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_raw_next    = vmin_reg;
                    m_corr_next   = corr_reg;
                    m_ocv_next    = ocv_reg;
                    m_cap_next    = cap_reg;
                    m_capped_next = (cap_reg < PCT_FULL);
                    m_comped_next = comped_reg;
                    m_hit_next    = hit_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready           = (state_reg == ST_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_raw_mv          = m_raw_reg;
    assign m_corr_mv         = $signed(m_corr_reg);
    assign m_ocv_est_mv      = m_ocv_reg;
    assign m_cap_pct         = m_cap_reg;
    assign m_is_capped       = m_capped_reg;
    assign m_was_compensated = m_comped_reg;
    assign m_hit_raw_floor   = m_hit_reg;

`ifndef SYNTHESIS
    a_cap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cap_pct <= PCT_FULL))
        else $error("cap percentage above full scale");

    a_capped_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_is_capped == (m_cap_pct < PCT_FULL)))
        else $error("capped flag disagrees with cap percentage");

    a_no_comp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_was_compensated) |-> (m_corr_mv == '0))
        else $error("correction reported without compensation");

    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second word accepted while one is in work");
`endif

endmodule

// ===== tb/tb_ir_compensated_cell_derate.sv =====
module tb_ir_compensated_cell_derate;
    timeunit 1ns;
    timeprecision 1ps;

    import icd_pkg::*;

    localparam int FRAC_BITS = 8;
    localparam int unsigned CAP_FULL = PCT_FULL;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PHASES = 8;
    localparam int WORDS_PER_PHASE = 120;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER [8] = '{
        REG_KNEE_MV, REG_FLOOR_MV, REG_FLOOR_PCT, REG_IR_MILLIOHM,
        REG_COMP_MAX_MV, REG_FILTER_SHIFT, REG_RAW_FLOOR_MV, REG_DEFAULT_MV
    };
    localparam int REG_WIDTH [8] = '{16, 16, 7, 8, 15, 4, 16, 16};

    typedef struct packed {
        logic               volt_fresh;
        logic [15:0]        cell_min_mv;
        logic               amp_fresh;
        logic signed [15:0] pack_curr;
    } cell_word_t;

    typedef struct packed {
        logic [15:0]        raw_mv;
        logic signed [15:0] corr_mv;
        logic [15:0]        ocv_est_mv;
        logic [6:0]         cap_pct;
        logic               is_capped;
        logic               was_compensated;
        logic               hit_raw_floor;
    } derate_word_t;

    typedef struct {
        logic [15:0] knee_mv;
        logic [15:0] floor_mv;
        logic [6:0]  floor_pct;
        logic [7:0]  ir_milliohm;
        logic [14:0] comp_max_mv;
        logic [3:0]  filter_shift;
        logic [15:0] raw_floor_mv;
        logic [15:0] default_mv;
    } derate_cfg_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_volt_fresh = 1'b0;
    logic [15:0]        s_cell_min_mv = '0;
    logic               s_amp_fresh = 1'b0;
    logic signed [15:0] s_pack_curr = '0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [15:0]        m_raw_mv;
    logic signed [15:0] m_corr_mv;
    logic [15:0]        m_ocv_est_mv;
    logic [6:0]         m_cap_pct;
    logic               m_is_capped;
    logic               m_was_compensated;
    logic               m_hit_raw_floor;

    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_wdata = '0;

    // local copy of the block's registers and filter state
    derate_cfg_t cfg = '{16'd3500, 16'd3000, 7'd20, 8'd0, 15'd500, 4'd3, 16'd2800, 16'd3600};
    bit          filt_seeded = 1'b0;
    int unsigned filt_acc = 0;

    cell_word_t   cell_word_q [$];
    derate_word_t derate_q [$];

    int  n_pushed = 0, n_accepted = 0, n_done = 0, n_err = 0, n_phases = 0;
    int  n_comp = 0, n_capped = 0, n_hit = 0, n_unusable = 0;
    int  s_gap = 0, m_stall = 0, cycle_cnt = 0;
    bit  s_idle_on = 1'b1, m_idle_on = 1'b1;

    ir_compensated_cell_derate #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_volt_fresh      (s_volt_fresh),
        .s_cell_min_mv     (s_cell_min_mv),
        .s_amp_fresh       (s_amp_fresh),
        .s_pack_curr       (s_pack_curr),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_raw_mv          (m_raw_mv),
        .m_corr_mv         (m_corr_mv),
        .m_ocv_est_mv      (m_ocv_est_mv),
        .m_cap_pct         (m_cap_pct),
        .m_is_capped       (m_is_capped),
        .m_was_compensated (m_was_compensated),
        .m_hit_raw_floor   (m_hit_raw_floor),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Work out the derate word for one accepted cell word and advance the filter.
    function automatic derate_word_t compute_derate(cell_word_t w);
        derate_word_t r;
        int corr, sum, lim;
        int unsigned tgt, drop, fp, cap, ocv, knee, flr;
        r.raw_mv = w.cell_min_mv;
        r.corr_mv = '0;
        r.was_compensated = 1'b0;
        r.hit_raw_floor = 1'b0;
        // unusable voltage: drop the seed, report defaults
        if (!w.volt_fresh || w.cell_min_mv == 0) begin
            filt_seeded = 1'b0;
            n_unusable++;
            r.ocv_est_mv = cfg.default_mv;
            r.cap_pct = PCT_FULL;
            r.is_capped = 1'b0;
            return r;
        end
        // ohmic correction, truncated toward zero, then clamped
        corr = 0;
        if (w.amp_fresh && cfg.ir_milliohm != 0) begin
            lim = int'(cfg.comp_max_mv);
            corr = int'(w.pack_curr) * int'(cfg.ir_milliohm) / 10;
            if (corr > lim) corr = lim;
            if (corr < -lim) corr = -lim;
            r.was_compensated = 1'b1;
        end
        r.corr_mv = corr[15:0];
        sum = int'(w.cell_min_mv) + corr;
        if (sum < 0) sum = 0;
        if (sum > 65535) sum = 65535;
        tgt = sum;
        tgt = tgt << FRAC_BITS;
        // low-pass step; the falling step rounds toward minus infinity
        if (!filt_seeded) begin
            filt_acc = tgt;
            filt_seeded = 1'b1;
        end else if (tgt >= filt_acc) begin
            filt_acc = filt_acc + ((tgt - filt_acc) >> cfg.filter_shift);
        end else begin
            drop = (filt_acc - tgt + ((32'd1 << cfg.filter_shift) - 32'd1)) >> cfg.filter_shift;
            filt_acc = filt_acc - drop;
        end
        ocv = (filt_acc >> FRAC_BITS) & 32'hFFFF;
        r.ocv_est_mv = ocv[15:0];
        // cap: raw backstop first, then knee, floor and interpolation
        fp = (cfg.floor_pct > CAP_FULL) ? CAP_FULL : cfg.floor_pct;
        knee = cfg.knee_mv;
        flr = cfg.floor_mv;
        if (w.cell_min_mv <= cfg.raw_floor_mv) begin
            r.hit_raw_floor = 1'b1;
            cap = fp;
        end else if (ocv >= knee) begin
            cap = CAP_FULL;
        end else if (ocv <= flr) begin
            cap = fp;
        end else begin
            cap = fp + ((CAP_FULL - fp) * (ocv - flr)) / (knee - flr);
        end
        r.cap_pct = cap[6:0];
        r.is_capped = (cap < CAP_FULL);
        return r;
    endfunction

    function automatic string derate_str(derate_word_t d);
        return $sformatf("raw=%0d corr=%0d ocv=%0d cap=%0d capped=%0b comp=%0b floor_hit=%0b",
                         d.raw_mv, d.corr_mv, d.ocv_est_mv, d.cap_pct, d.is_capped,
                         d.was_compensated, d.hit_raw_floor);
    endfunction

    function automatic int draw_gap(bit on);
        return on ? int'($urandom_range(0, 8)) : 0;
    endfunction

    task automatic push_word(input bit vf, input int mv, input bit af, input int cur);
        cell_word_t w;
        w.volt_fresh = vf;
        w.cell_min_mv = 16'(mv);
        w.amp_fresh = af;
        w.pack_curr = 16'(cur);
        cell_word_q.push_back(w);
        n_pushed++;
    endtask

    // Wait for the block to drain, then write all eight registers with junk above
    // each register's width.
    task automatic apply_cfg(input int unsigned knee, flr, fpct, ir, cmax, shift, rawfl, dflt);
        int unsigned vals [8];
        logic [15:0] mask, wdata;
        vals = '{knee, flr, fpct, ir, cmax, shift, rawfl, dflt};
        while (n_done != n_pushed) @(posedge aclk);
        for (int i = 0; i < 8; i++) begin
            mask = 16'((32'd1 << REG_WIDTH[i]) - 1);
            wdata = (16'(vals[i]) & mask) | (16'($urandom) & ~mask);
            @(posedge aclk);
            cfg_wr_en <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_wdata <= wdata;
            case (REG_ORDER[i])
                REG_KNEE_MV:      cfg.knee_mv = wdata;
                REG_FLOOR_MV:     cfg.floor_mv = wdata;
                REG_FLOOR_PCT:    cfg.floor_pct = wdata[6:0];
                REG_IR_MILLIOHM:  cfg.ir_milliohm = wdata[7:0];
                REG_COMP_MAX_MV:  cfg.comp_max_mv = wdata[14:0];
                REG_FILTER_SHIFT: cfg.filter_shift = wdata[3:0];
                REG_RAW_FLOOR_MV: cfg.raw_floor_mv = wdata;
                REG_DEFAULT_MV:   cfg.default_mv = wdata;
                default: ;
            endcase
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        n_phases++;
    endtask

    // Drive cell words: predict on acceptance, then hold off for the drawn gap.
    always @(posedge aclk) begin
        cell_word_t w;
        int gap;
        bit took;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_gap <= 0;
        end else begin
            took = s_valid && s_ready;
            if (took) begin
                w.volt_fresh = s_volt_fresh;
                w.cell_min_mv = s_cell_min_mv;
                w.amp_fresh = s_amp_fresh;
                w.pack_curr = s_pack_curr;
                derate_q.push_back(compute_derate(w));
                n_accepted++;
            end
            if (took || !s_valid) begin
                gap = took ? draw_gap(s_idle_on) : s_gap;
                if (gap == 0 && cell_word_q.size() != 0) begin
                    w = cell_word_q.pop_front();
                    s_volt_fresh <= w.volt_fresh;
                    s_cell_min_mv <= w.cell_min_mv;
                    s_amp_fresh <= w.amp_fresh;
                    s_pack_curr <= w.pack_curr;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                    s_gap <= (gap == 0) ? 0 : gap - 1;
                end
            end
        end
    end

    // Check each result word against the oldest prediction, then stall as drawn.
    always @(posedge aclk) begin
        derate_word_t got, exp;
        string bad;
        int stall;
        bit took;
        if (!aresetn) begin
            m_ready <= 1'b0;
            m_stall <= 0;
        end else begin
            took = m_valid && m_ready;
            if (took) begin
                got.raw_mv = m_raw_mv;
                got.corr_mv = m_corr_mv;
                got.ocv_est_mv = m_ocv_est_mv;
                got.cap_pct = m_cap_pct;
                got.is_capped = m_is_capped;
                got.was_compensated = m_was_compensated;
                got.hit_raw_floor = m_hit_raw_floor;
                if (derate_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("ERROR: result word with nothing expected: %s", derate_str(got));
                end else begin
                    exp = derate_q.pop_front();
                    n_done++;
                    bad = "";
                    if (got.raw_mv !== exp.raw_mv) bad = {bad, " raw_mv"};
                    if (got.corr_mv !== exp.corr_mv) bad = {bad, " corr_mv"};
                    if (got.ocv_est_mv !== exp.ocv_est_mv) bad = {bad, " ocv_est_mv"};
                    if (got.cap_pct !== exp.cap_pct) bad = {bad, " cap_pct"};
                    if (got.is_capped !== exp.is_capped) bad = {bad, " is_capped"};
                    if (got.was_compensated !== exp.was_compensated)
                        bad = {bad, " was_compensated"};
                    if (got.hit_raw_floor !== exp.hit_raw_floor) bad = {bad, " hit_raw_floor"};
                    if (bad != "") begin
                        n_err++;
                        if (n_err <= 10) begin
                            $display("ERROR: word %0d mismatch in%s", n_done, bad);
                            $display("  expected %s", derate_str(exp));
                            $display("  actual   %s", derate_str(got));
                        end
                    end
                    n_comp += exp.was_compensated;
                    n_capped += exp.is_capped;
                    n_hit += exp.hit_raw_floor;
                end
            end
            stall = took ? draw_gap(m_idle_on) : m_stall;
            if (stall == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                m_stall <= stall - 1;
            end
        end
    end

    // Bound the run.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d of %0d words done",
                     cycle_cnt, n_done, n_pushed);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int drift, mode, mv, cur, sel, base;
        bit vf, af;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: unusable voltage, seeding, filter, raw backstop edges
        push_word(0, 3300, 1, 100);
        push_word(1, 0, 1, 100);
        push_word(1, 3600, 1, 500);
        push_word(1, 3200, 0, 0);
        push_word(1, 65535, 1, 0);
        push_word(1, 1, 1, 0);
        push_word(1, 2800, 1, 0);
        push_word(1, 2801, 1, 0);

        // full correction, no filtering: clamps, truncation, knee and floor edges
        apply_cfg(3500, 3000, 20, 255, 32767, 0, 2800, 3600);
        push_word(1, 65535, 1, 32767);
        push_word(1, 100, 1, -32768);
        push_word(1, 3250, 0, -32768);
        push_word(1, 3250, 1, -1);
        push_word(1, 3250, 1, -3);
        push_word(1, 3500, 1, 0);
        push_word(1, 3499, 1, 0);
        push_word(1, 3000, 1, 0);
        push_word(1, 3001, 1, 0);

        // knee below floor, floor percentage above 100, zero correction limit
        apply_cfg(3000, 3500, 127, 10, 0, 15, 0, 0);
        push_word(0, 3000, 1, 0);
        push_word(1, 3200, 1, 1000);
        push_word(1, 2000, 1, -1000);
        push_word(0, 2000, 1, 0);
        push_word(1, 2500, 0, 0);

        // knee equal to floor, zero floor percentage
        apply_cfg(3200, 3200, 0, 0, 500, 1, 0, 65535);
        push_word(1, 3200, 1, 0);
        push_word(0, 3200, 1, 0);
        push_word(1, 3199, 1, 0);
        push_word(1, 65535, 1, 0);

        // random phases, the first two at register extremes
        drift = 3400;
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: apply_cfg(65535, 0, 0, 255, 32767, 15, 0, 65535);
                1: apply_cfg(0, 65535, 100, 1, 0, 0, 65535, 0);
                default: apply_cfg($urandom_range(3300, 4200), $urandom_range(2600, 3400),
                                   $urandom_range(0, 127),
                                   ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 255),
                                   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                               : $urandom_range(0, 1000),
                                   $urandom_range(0, 15), $urandom_range(2200, 3200),
                                   $urandom_range(0, 65535));
            endcase
            s_idle_on = (p == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            m_idle_on = (p == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                vf = 1'b1;
                mode = $urandom_range(0, 99);
                if (mode < 8) begin
                    // unusable: stale flag or zero reading
                    vf = $urandom_range(0, 1);
                    mv = vf ? 0 : $urandom_range(0, 65535);
                end else if (mode < 70) begin
                    // slow drift through the derate band keeps the filter seeded
                    drift = drift + $urandom_range(0, 200) - 100;
                    if (drift < 2300) drift = 2300;
                    if (drift > 4500) drift = 4500;
                    mv = drift;
                end else if (mode < 85) begin
                    mv = $urandom_range(0, 65535);
                end else begin
                    // land on or beside a threshold
                    sel = $urandom_range(0, 2);
                    base = (sel == 0) ? cfg.knee_mv : (sel == 1) ? cfg.floor_mv
                                                                : cfg.raw_floor_mv;
                    mv = base + $urandom_range(0, 2) - 1;
                    if (mv < 0) mv = 0;
                    if (mv > 65535) mv = 65535;
                end
                af = ($urandom_range(0, 9) != 0);
                mode = $urandom_range(0, 99);
                if (mode < 60) begin
                    cur = $urandom_range(0, 6000) - 3000;
                end else if (mode < 85) begin
                    cur = $urandom_range(0, 65535);
                end else begin
                    sel = $urandom_range(0, 4);
                    cur = (sel == 0) ? -32768 : (sel == 1) ? 32767 : (sel == 2) ? -1
                        : (sel == 3) ? 1 : 0;
                end
                push_word(vf, mv, af, cur);
            end
        end

        // drain, then watch for stray words
        while (n_done != n_pushed) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (derate_q.size() != 0) begin
            n_err += derate_q.size();
            $display("ERROR: %0d predicted words never came out", derate_q.size());
        end
        $display("Ran %0d cell words over %0d register settings, %0d mismatches.",
                 n_accepted, n_phases + 1, n_err);
        $display("Seen: %0d corrected, %0d capped, %0d raw backstops, %0d unusable voltage.",
                 n_comp, n_capped, n_hit, n_unusable);
        if (n_err == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/icd_pkg.sv
sv/icd_ser_mult.sv
sv/icd_ser_div.sv
sv/ir_compensated_cell_derate.sv
tb/tb_ir_compensated_cell_derate.sv
